### src/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk and
// is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/ncc_pkg.sv
`timescale 1ns / 1ps

package ncc_pkg;

  // Patch and store geometry.
  localparam int PATCH_SIDE = 15;
  localparam int MAX_POSITIVE = 64;
  localparam int MAX_NEGATIVE = 64;
  localparam int PATCH_LEN = PATCH_SIDE * PATCH_SIDE;
  localparam int NUM_SLOTS = MAX_POSITIVE + MAX_NEGATIVE;
  localparam int MAX_STORE = (MAX_POSITIVE > MAX_NEGATIVE) ? MAX_POSITIVE : MAX_NEGATIVE;

  localparam int PIX_IDX_W = $clog2(PATCH_LEN);
  localparam int ELEM_CNT_W = $clog2(PATCH_LEN + 1);
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TADDR_W = $clog2(NUM_SLOTS * PATCH_LEN);
  localparam int CNT_W = $clog2(MAX_STORE + 1);

  // A square of one element is at most 2^30, so sums of PATCH_LEN of them fit here.
  localparam int ENERGY_W = 30 + ELEM_CNT_W;
  localparam int ACC_W = ENERGY_W + 1;
  localparam int SQRT_W = (ENERGY_W + 1) / 2;
  localparam int DIV_W = 2 * SQRT_W;

  // Q1.15 values.
  localparam int Q_FRAC = 15;
  localparam int CONF_W = 16;
  localparam logic [CONF_W-1:0] Q_ONE = 16'd32768;
  localparam logic [CONF_W-1:0] Q_HALF = 16'd16384;

  // Field widths on the ports.
  localparam int PIX_W = 16;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THETA_TP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THETA_FP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 2'd2;

  localparam logic [15:0] THETA_TP_RESET = 16'd21299;
  localparam logic [15:0] THETA_FP_RESET = 16'd16384;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic sqrt_start;
    logic tpl_init;
    logic sweep_start;
    logic sweep_copy;
    logic mul;
    logic div_start;
    logic div_conf;
    logic best_upd;
    logic conf_ld;
    logic decide;
    logic out_ld;
  } ncc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_done;
    logic sweep_done;
    logic div_done;
    logic pos_zero;
    logic neg_zero;
    logic last_tpl;
    logic do_copy;
    logic out_free;
  } ncc_sts_t;

endpackage

### src/ncc_div.sv
`timescale 1ns / 1ps

// Restoring fractional divider: q = floor(num * 2^15 / den) for num < den.
// One quotient bit per cycle.
module ncc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ncc_pkg::DIV_W-1:0]     num,
  input  logic [ncc_pkg::DIV_W-1:0]     den,
  output logic [ncc_pkg::Q_FRAC-1:0]    quot,
  output logic                          done
);

  localparam int STEP_W = $clog2(ncc_pkg::Q_FRAC + 1);

  logic [ncc_pkg::DIV_W-1:0]  rem_r;
  logic [ncc_pkg::DIV_W-1:0]  den_r;
  logic [ncc_pkg::Q_FRAC-1:0] quot_r;
  logic [STEP_W-1:0]          step_r;
  logic                       busy_r;
  logic                       done_r;
  logic [ncc_pkg::DIV_W:0]    trial;
  logic                       ge;

  assign trial = {rem_r, 1'b0};
  assign ge = trial >= {1'b0, den_r};

  // Control: count the quotient bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(ncc_pkg::Q_FRAC);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift, compare and subtract.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? ncc_pkg::DIV_W'(trial - {1'b0, den_r}) : trial[ncc_pkg::DIV_W-1:0];
      quot_r <= {quot_r[ncc_pkg::Q_FRAC-2:0], ge};
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

### src/ncc_isqrt.sv
`timescale 1ns / 1ps

// Floor square root, two radicand bits per cycle.
module ncc_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ncc_pkg::ENERGY_W-1:0]  val,
  output logic [ncc_pkg::SQRT_W-1:0]    root,
  output logic                          done
);

  localparam int SW = ncc_pkg::SQRT_W;
  localparam int RAD_W = 2 * SW;
  localparam int STEP_W = $clog2(SW + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [SW+1:0]     rem_r;
  logic [SW-1:0]     root_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [SW+1:0]     rem_sh;
  logic [SW+1:0]     trial;
  logic              ge;

  assign rem_sh = {rem_r[SW-1:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial = {root_r, 2'b01};
  assign ge = rem_sh >= trial;

  // Control: one result bit per step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SW);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: bring down two bits and try the next root bit.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'(val);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[SW-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

### src/ncc_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: collects a patch, walks the templates, computes the
// confidence, learns and hands the result to the output register.
module ncc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  ncc_pkg::ncc_sts_t sts,
  output ncc_pkg::ncc_cmd_t cmd
);

  typedef enum logic [14:0] {
    S_RECV   = 15'b000000000000001,
    S_DRAIN  = 15'b000000000000010,
    S_SQST   = 15'b000000000000100,
    S_SQWT   = 15'b000000000001000,
    S_MAC    = 15'b000000000010000,
    S_MUL    = 15'b000000000100000,
    S_QDIV   = 15'b000000001000000,
    S_QWT    = 15'b000000010000000,
    S_BEST   = 15'b000000100000000,
    S_CDIV   = 15'b000001000000000,
    S_CWT    = 15'b000010000000000,
    S_CONF   = 15'b000100000000000,
    S_DECIDE = 15'b001000000000000,
    S_COPY   = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_RECV);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_RECV: begin
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (in_tlast) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      // The last square is still being added to the energy.
      S_DRAIN: begin
        state_nxt = S_SQST;
      end
      S_SQST: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = S_SQWT;
      end
      S_SQWT: begin
        if (sts.sqrt_done) begin
          if (sts.pos_zero || sts.neg_zero) begin
            state_nxt = S_CONF;
          end else begin
            cmd.tpl_init = 1'b1;
            cmd.sweep_start = 1'b1;
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        if (sts.sweep_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_QDIV;
      end
      S_QDIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_QWT;
      end
      S_QWT: begin
        if (sts.div_done) begin
          state_nxt = S_BEST;
        end
      end
      S_BEST: begin
        cmd.best_upd = 1'b1;
        if (sts.last_tpl) begin
          state_nxt = S_CDIV;
        end else begin
          cmd.sweep_start = 1'b1;
          state_nxt = S_MAC;
        end
      end
      S_CDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_conf = 1'b1;
        state_nxt = S_CWT;
      end
      S_CWT: begin
        if (sts.div_done) begin
          state_nxt = S_CONF;
        end
      end
      S_CONF: begin
        cmd.conf_ld = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.do_copy) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_copy = 1'b1;
          state_nxt = S_COPY;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_COPY: begin
        if (sts.sweep_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt = S_RECV;
        end
      end
      default: begin
        state_nxt = S_RECV;
      end
    endcase
  end

endmodule

### src/ncc_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Datapath: patch buffer, template stores, MAC pipeline, square root,
// divider, best-match tracking, learning and the output register.
module ncc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ncc_pkg::ncc_cmd_t                  cmd,
  output ncc_pkg::ncc_sts_t                  sts,
  input  logic [ncc_pkg::PIX_W-1:0]          in_pix,
  input  logic                               in_last,
  input  logic                               in_mode,
  input  logic                               in_label,
  input  logic                               cfg_we,
  input  logic [ncc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ncc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ncc_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int CW = ncc_pkg::CNT_W;
  localparam int SW = ncc_pkg::SLOT_W;
  localparam int AW = ncc_pkg::TADDR_W;

  // Configuration registers.
  logic [15:0] theta_tp_r;
  logic [15:0] theta_fp_r;
  logic        filter_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_tp_r  <= ncc_pkg::THETA_TP_RESET;
      theta_fp_r  <= ncc_pkg::THETA_FP_RESET;
      filter_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ncc_pkg::CFG_THETA_TP:  theta_tp_r  <= cfg_wdata;
        ncc_pkg::CFG_THETA_FP:  theta_fp_r  <= cfg_wdata;
        ncc_pkg::CFG_FILTER_EN: filter_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Element counter, energy and latched learn request.
  logic [ncc_pkg::ELEM_CNT_W-1:0] idx_r;
  logic [ncc_pkg::ENERGY_W-1:0]   energy_r;
  logic signed [31:0]             sq_r;
  logic                           sq_v_r;
  logic                           learn_r;
  logic                           label_r;
  logic                           room;

  assign room = idx_r < ncc_pkg::ELEM_CNT_W'(ncc_pkg::PATCH_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      energy_r <= '0;
      sq_v_r   <= 1'b0;
    end else begin
      sq_v_r <= cmd.take && room;
      if (cmd.out_ld) begin
        idx_r    <= '0;
        energy_r <= '0;
      end else begin
        if (cmd.take && room) begin
          idx_r <= idx_r + 1'b1;
        end
        if (sq_v_r) begin
          energy_r <= energy_r + ncc_pkg::ENERGY_W'(sq_r[30:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= $signed(in_pix) * $signed(in_pix);
    if (cmd.take && in_last) begin
      learn_r <= in_mode;
      label_r <= in_label;
    end
  end

  // Square root of the patch energy.
  logic [ncc_pkg::SQRT_W-1:0] psq;
  logic                       sqrt_done;

  ncc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .val   (energy_r),
    .root  (psq),
    .done  (sqrt_done)
  );

  // Template walk: side 0 is the positive store, side 1 the negative one.
  logic [CW-1:0] pos_total_r;
  logic [CW-1:0] neg_total_r;
  logic [CW-1:0] k_r;
  logic          side_r;
  logic          last_pos;
  logic          last_neg;
  logic [SW-1:0] read_slot;
  logic [SW-1:0] store_slot;
  logic          sp_r;
  logic          sn_r;
  logic          drop_r;

  assign last_pos = (k_r == pos_total_r - 1'b1);
  assign last_neg = (k_r == neg_total_r - 1'b1);
  assign read_slot = side_r ? SW'(ncc_pkg::MAX_POSITIVE) + SW'(k_r) : SW'(k_r);
  assign store_slot = sp_r ? SW'(pos_total_r) : SW'(ncc_pkg::MAX_POSITIVE) + SW'(neg_total_r);

  // Sweep engine over the patch elements, shared by MAC and copy.
  logic                           run_r;
  logic                           copy_r;
  logic [ncc_pkg::PIX_IDX_W-1:0]  i_r;
  logic [SW-1:0]                  slot0;
  logic [AW-1:0]                  addr0;
  logic                           s1_v_r;
  logic                           s1_mask_r;
  logic [AW-1:0]                  s1_addr_r;
  logic [ncc_pkg::PIX_W-1:0]      pbuf_q;
  logic [ncc_pkg::PIX_W-1:0]      tmem_q;
  logic [ncc_pkg::PIX_W-1:0]      pix_m;
  logic                           s2_v_r;
  logic signed [31:0]             prod_r;
  logic signed [ncc_pkg::ACC_W-1:0] acc_r;

  assign slot0 = copy_r ? store_slot : read_slot;
  assign addr0 = AW'(slot0) * AW'(ncc_pkg::PATCH_LEN) + AW'(i_r);
  assign pix_m = s1_mask_r ? pbuf_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      copy_r <= 1'b0;
      i_r    <= '0;
    end else begin
      s1_v_r <= run_r;
      s2_v_r <= s1_v_r && !copy_r;
      if (cmd.sweep_start) begin
        run_r  <= 1'b1;
        i_r    <= '0;
        copy_r <= cmd.sweep_copy;
      end else if (run_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == ncc_pkg::PIX_IDX_W'(ncc_pkg::PATCH_LEN - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Patch buffer memory.
  logic [ncc_pkg::PIX_W-1:0] pbuf [ncc_pkg::PATCH_LEN];

  always_ff @(posedge clk) begin
    if (cmd.take && room) begin
      pbuf[idx_r[ncc_pkg::PIX_IDX_W-1:0]] <= in_pix;
    end
    pbuf_q <= pbuf[i_r];
  end

  // Template store for both sides; elements past the patch length are zero.
  logic [ncc_pkg::PIX_W-1:0] tmem [ncc_pkg::NUM_SLOTS * ncc_pkg::PATCH_LEN];

  always_ff @(posedge clk) begin
    if (s1_v_r && copy_r) begin
      tmem[s1_addr_r] <= pix_m;
    end
    tmem_q <= tmem[addr0];
  end

  // Square roots of the template energies.
  logic [ncc_pkg::SQRT_W-1:0] tsq [ncc_pkg::NUM_SLOTS];
  logic [ncc_pkg::SQRT_W-1:0] tsq_q;

  always_ff @(posedge clk) begin
    if (cmd.out_ld && (sp_r || sn_r)) begin
      tsq[store_slot] <= psq;
    end
    tsq_q <= tsq[read_slot];
  end

  // MAC pipeline: read, multiply, accumulate.
  always_ff @(posedge clk) begin
    s1_mask_r <= ncc_pkg::ELEM_CNT_W'(i_r) < idx_r;
    s1_addr_r <= addr0;
    prod_r    <= $signed(pix_m) * $signed(tmem_q);
    if (cmd.sweep_start) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + ncc_pkg::ACC_W'(prod_r);
    end
  end

  // Denominator and magnitude of the correlation.
  logic [ncc_pkg::DIV_W-1:0] denom_r;
  logic [ncc_pkg::DIV_W-1:0] mag_r;
  logic                      neg_r;
  logic [ncc_pkg::ACC_W-1:0] acc_abs;

  assign acc_abs = acc_r[ncc_pkg::ACC_W-1] ? ncc_pkg::ACC_W'(-acc_r) : ncc_pkg::ACC_W'(acc_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      denom_r <= psq * tsq_q;
      mag_r   <= ncc_pkg::DIV_W'(acc_abs[ncc_pkg::ENERGY_W-1:0]);
      neg_r   <= acc_r[ncc_pkg::ACC_W-1];
    end
  end

  // Shared divider for the match value and the confidence.
  logic [15:0]               best_p_r;
  logic [15:0]               best_n_r;
  logic [16:0]               dp;
  logic [16:0]               dn;
  logic [17:0]               dsum;
  logic [ncc_pkg::Q_FRAC-1:0] quot;
  logic                      div_done;

  assign dp = 17'(ncc_pkg::Q_ONE) - {1'b0, best_p_r};
  assign dn = 17'(ncc_pkg::Q_ONE) - {1'b0, best_n_r};
  assign dsum = {1'b0, dp} + {1'b0, dn};

  ncc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_conf ? ncc_pkg::DIV_W'(dn) : mag_r),
    .den   (cmd.div_conf ? ncc_pkg::DIV_W'(dsum) : denom_r),
    .quot  (quot),
    .done  (div_done)
  );

  // Mapped match value of the current template.
  logic [16:0] q_full;
  logic [17:0] mapped;
  logic [15:0] match;

  assign q_full = (mag_r >= denom_r) ? 17'(ncc_pkg::Q_ONE) : 17'(quot);
  assign mapped = neg_r ? (18'(ncc_pkg::Q_ONE) - 18'(q_full)) >> 1
                        : (18'(ncc_pkg::Q_ONE) + 18'(q_full)) >> 1;
  assign match = (denom_r == '0) ? ncc_pkg::Q_HALF : mapped[15:0];

  // Best matches and the walk over the stores.
  always_ff @(posedge clk) begin
    if (cmd.tpl_init) begin
      best_p_r <= '0;
      best_n_r <= '0;
      k_r      <= '0;
      side_r   <= 1'b0;
    end else if (cmd.best_upd) begin
      if (!side_r && match > best_p_r) begin
        best_p_r <= match;
      end
      if (side_r && match > best_n_r) begin
        best_n_r <= match;
      end
      if (!side_r && last_pos) begin
        side_r <= 1'b1;
        k_r    <= '0;
      end else begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // Confidence and learning decision.
  logic [15:0] conf_r;
  logic        pos_full;
  logic        neg_full;
  logic        want_p;
  logic        want_n;
  logic        sp;
  logic        sn;

  assign pos_full = pos_total_r >= CW'(ncc_pkg::MAX_POSITIVE);
  assign neg_full = neg_total_r >= CW'(ncc_pkg::MAX_NEGATIVE);
  assign want_p = learn_r && label_r && (conf_r <= theta_tp_r);
  assign want_n = learn_r && !label_r && (conf_r >= theta_fp_r);
  assign sp = want_p && !pos_full;
  assign sn = want_n && !neg_full;

  always_ff @(posedge clk) begin
    if (cmd.conf_ld) begin
      if (pos_total_r == '0) begin
        conf_r <= '0;
      end else if (neg_total_r == '0) begin
        conf_r <= ncc_pkg::Q_ONE;
      end else if (dsum == '0) begin
        conf_r <= ncc_pkg::Q_HALF;
      end else if (dp == '0) begin
        conf_r <= ncc_pkg::Q_ONE;
      end else begin
        conf_r <= 16'(quot);
      end
    end
    if (cmd.decide) begin
      sp_r   <= sp;
      sn_r   <= sn;
      drop_r <= (want_p && pos_full) || (want_n && neg_full);
    end
  end

  // Store counts and the output register.
  logic        out_v_r;
  logic [15:0] o_conf_r;
  logic        o_acc_r;
  logic        o_sp_r;
  logic        o_sn_r;
  logic        o_drop_r;
  logic [CW-1:0] pos_nxt;
  logic [CW-1:0] neg_nxt;

  assign pos_nxt = pos_total_r + CW'(sp_r);
  assign neg_nxt = neg_total_r + CW'(sn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      pos_total_r <= '0;
      neg_total_r <= '0;
    end else begin
      if (cmd.out_ld) begin
        out_v_r     <= 1'b1;
        pos_total_r <= pos_nxt;
        neg_total_r <= neg_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      o_conf_r <= conf_r;
      o_acc_r  <= !filter_en_r || (conf_r >= theta_tp_r);
      o_sp_r   <= sp_r;
      o_sn_r   <= sn_r;
      o_drop_r <= drop_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data = {6'b0, ncc_pkg::COUNT_OUT_W'(neg_total_r), ncc_pkg::COUNT_OUT_W'(pos_total_r),
                     o_drop_r, o_sn_r, o_sp_r, o_acc_r, o_conf_r};

  // Status back to the controller.
  always_comb begin
    sts.sqrt_done  = sqrt_done;
    sts.sweep_done = !run_r && !s1_v_r && !s2_v_r;
    sts.div_done   = div_done;
    sts.pos_zero   = (pos_total_r == '0);
    sts.neg_zero   = (neg_total_r == '0);
    sts.last_tpl   = side_r && last_neg;
    sts.do_copy    = sp || sn;
    sts.out_free   = !out_v_r || out_ready;
  end

  `ASSERT_ALWAYS(a_counts_bounded, (pos_total_r <= CW'(ncc_pkg::MAX_POSITIVE)) && (neg_total_r <= CW'(ncc_pkg::MAX_NEGATIVE)), "store count past its capacity")
  `ASSERT_IMPLIES(a_one_store, out_v_r, !(o_sp_r && o_sn_r) && (o_conf_r <= ncc_pkg::Q_ONE), "bad result flags")
  `ASSERT_IMPLIES(a_sweep_idle, cmd.sweep_start, !run_r && !s1_v_r && !s2_v_r, "sweep restarted while busy")

endmodule

### src/ncc_nearest_neighbour_classifier_top.sv
`timescale 1ns / 1ps

// Nearest-neighbor patch classifier with normalized cross correlation.
// Input stream: one signed Q8.7 patch element per beat in in_tdata, in_tlast
// closes the patch, in_tuser carries the learn mode and label. Output stream:
// one beat per patch with the Q1.15 confidence, accept and learn flags and
// the store counts. The configuration port writes theta_tp, theta_fp and the
// filter enable; writing them only while the block is idle is up to the user,
// as the block itself does not enforce it. Elements are taken one per cycle.
// After the last element the block computes the patch norm (a 2-bit-per-step
// square root), then per stored template a single-MAC sweep over the template
// memory plus a bit-serial 15-step divide. The confidence divide follows, and
// learning copies the patch into the store. With no positives or no negatives
// the template sweep and the confidence divide are skipped.
// Input is not taken while a patch is being evaluated. The result sits in an
// output register, so collection of the next patch starts as soon as the
// result is loaded; a stalled receiver only holds the next result back.
// Reset empties both stores and the patch; no memory clearing pass is run.
module ncc_nearest_neighbour_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [15:0] pixel_value.
  input  logic [15:0] in_tdata,
  input  logic        in_tlast,
  // in_tuser: [0] mode, [1] label_positive.
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [15:0] confidence, [16] accepted, [17] stored_as_positive,
  // [18] stored_as_negative, [19] dropped_store_full, [26:20] positive_count,
  // [33:27] negative_count, [39:34] zero.
  output logic [39:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  ncc_pkg::ncc_cmd_t cmd;
  ncc_pkg::ncc_sts_t sts;

  ncc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ncc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_pix    (in_tdata),
    .in_last   (in_tlast),
    .in_mode   (in_tuser[0]),
    .in_label  (in_tuser[1]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
